### rtl/bsg_pkg.sv
// Shared constants, handshake structs and saturation helper for the scan generator.
`timescale 1ns / 1ps

package bsg_pkg;

  // Field widths of the ports.
  localparam int ANGLE_W   = 16;
  localparam int SCALE_W   = 16;
  localparam int LINES_W   = 5;
  localparam int INTERP_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Bottom-line yaw factor is unsigned Q2.14.
  localparam int SCALE_SHIFT = 14;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  // Serial divider widths: dividend covers line * span, divisor covers up to 63.
  localparam int DIV_W = 24;
  localparam int DVS_W = 6;

  // Width of intermediate values handed to the saturation helper.
  localparam int SAT_W = 40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_LINES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LEFT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_RIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_UP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_DOWN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_COUNT = 3'd6;

  // Reset values of the configuration registers.
  localparam int RST_SCAN_LINES = 3;
  localparam int RST_SCALE      = 16384;

  // Request into the serial divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // Response from the serial divider; done pulses for one cycle.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  // Clamp a wide signed value into the signed angle range.
  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0]   hi;
    logic signed [SAT_W-1:0]   lo;
    logic signed [ANGLE_W-1:0] res;
    hi = SAT_W'(2 ** (ANGLE_W - 1) - 1);
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      res = hi[ANGLE_W-1:0];
    end else if (v < lo) begin
      res = lo[ANGLE_W-1:0];
    end else begin
      res = v[ANGLE_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/bsg_channels.sv
// Handshake channel interfaces: input item, result keyframe and configuration write.
`timescale 1ns / 1ps

interface bsg_item_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface bsg_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bsg_pkg::ANGLE_W-1:0]   yaw;
  logic signed [bsg_pkg::ANGLE_W-1:0]   pitch;
  logic                                 last_of_step;
  logic                                 pattern_end;

  modport source (output valid, output yaw, output pitch, output last_of_step,
                  output pattern_end, input ready);
  modport sink (input valid, input yaw, input pitch, input last_of_step,
                input pattern_end, output ready);
endinterface

interface bsg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bsg_pkg::CFG_IDX_W-1:0]      index;
  logic [bsg_pkg::CFG_DAT_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/bsg_divider.sv
// Restoring unsigned serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bsg_divider (
  input  logic              clk,
  input  logic              rst,
  input  bsg_pkg::div_req_t req,
  output bsg_pkg::div_rsp_t rsp
);
  import bsg_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = (shifted >= {1'b0, dvs});
  end

  // Control: count down the quotient bits and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: divisor held for the whole division, remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DVS_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DVS_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### rtl/boustrophedon_scan_generator.sv
// Top level of the back-and-forth pan-tilt scan pattern generator.
`timescale 1ns / 1ps

// Each input beat advances the scan pattern by one iteration and produces one corner
// keyframe, followed on a horizontal sweep with nonzero interp_count by interp_count+1
// interpolated yaw points (at most MAX_INTERP+1). The block handles one input beat at
// a time: a corner passes through the serial divider that places the scan line's
// pitch, a sweep with points makes a second pass through the divider, and the result
// consumer may stall the output. The corner of a single-line pattern skips the divider.
// Angles are signed Q3.12 radians; the bottom-line yaw factor is unsigned Q2.14.
// Divisions truncate toward zero and every computed angle saturates. Configuration
// writes are always accepted and must only be made while the block is idle.
module boustrophedon_scan_generator #(
  parameter int MAX_LINES  = 16,
  parameter int MAX_INTERP = 15
) (
  input  logic         clk,
  input  logic         rst,
  bsg_item_if.sink     item,
  bsg_result_if.source result,
  bsg_cfg_if.sink      cfg
);
  import bsg_pkg::*;

  localparam int LCW = $clog2(MAX_LINES + 1);
  localparam int ITW = $clog2(4 * MAX_LINES + 1);
  localparam int IW  = $clog2(MAX_INTERP + 2);
  localparam int RW  = DVS_W + 2;
  localparam int RST_LINE_INDEX =
    ((RST_SCAN_LINES > MAX_LINES) ? MAX_LINES : RST_SCAN_LINES) - 1;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_PMUL  = 4'd2;
  localparam logic [3:0] ST_PDIV  = 4'd3;
  localparam logic [3:0] ST_PWAIT = 4'd4;
  localparam logic [3:0] ST_YSCL  = 4'd5;
  localparam logic [3:0] ST_YRND  = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;
  localparam logic [3:0] ST_IDIV  = 4'd8;
  localparam logic [3:0] ST_IWAIT = 4'd9;
  localparam logic [3:0] ST_POINT = 4'd10;
  localparam logic [3:0] ST_STEP  = 4'd11;
  localparam logic [3:0] ST_UPD   = 4'd12;

  // Configuration registers.
  logic [LINES_W-1:0]        scan_lines;
  logic signed [ANGLE_W-1:0] yaw_left;
  logic signed [ANGLE_W-1:0] yaw_right;
  logic signed [ANGLE_W-1:0] pitch_up;
  logic signed [ANGLE_W-1:0] pitch_down;
  logic [SCALE_W-1:0]        bottom_yaw_scale;
  logic [INTERP_W-1:0]       interp_count;

  // Pattern state.
  logic [LCW-1:0] line_index;
  logic           going_up;
  logic           on_right;
  logic           heading_right;
  logic [ITW-1:0] iteration_count;

  // Per-item working registers.
  logic [3:0]                state;
  logic                      restart_req;
  logic                      end_flag;
  logic                      interp_mode;
  logic                      in_points;
  logic signed [ANGLE_W-1:0] pitch_r;
  logic signed [ANGLE_W-1:0] yaw_r;
  logic signed [PROD_W-1:0]  mprod;
  logic [IW-1:0]             divn;
  logic [IW-1:0]             pts_left;
  logic [ANGLE_W:0]          step_q;
  logic [DVS_W-1:0]          step_r;
  logic [ANGLE_W:0]          acc_q;
  logic [DVS_W-1:0]          acc_r;

  // Output register.
  logic                      out_valid;
  logic signed [ANGLE_W-1:0] out_yaw;
  logic signed [ANGLE_W-1:0] out_pitch;
  logic                      out_last;
  logic                      out_end;

  // Divider connection.
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Combinational helpers.
  logic [LCW-1:0]            l_eff;
  logic [ITW-1:0]            total;
  logic                      end_calc;
  logic [IW-1:0]             divn_calc;
  logic signed [ANGLE_W:0]   pdiff;
  logic [ANGLE_W:0]          pspan;
  logic signed [ANGLE_W:0]   ydiff;
  logic [ANGLE_W:0]          yspan;
  logic signed [ANGLE_W-1:0] key_yaw;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mround;
  logic signed [SAT_W-1:0]   pitch_sum;
  logic signed [SAT_W-1:0]   point_sum;
  logic signed [LCW+1:0]     nl_raw;
  logic signed [LCW+1:0]     nl_max;
  logic signed [LCW+1:0]     nl_sat;
  logic                      emit_fire;
  logic                      emit_last;
  logic signed [RW-1:0]      r_dn;
  logic signed [RW-1:0]      r_up;

  // Effective line count, pattern length and interpolation divisor.
  always_comb begin
    if (scan_lines == '0) begin
      l_eff = LCW'(1);
    end else if (32'(scan_lines) > MAX_LINES) begin
      l_eff = LCW'(MAX_LINES);
    end else begin
      l_eff = LCW'(scan_lines);
    end
    total     = (l_eff >= LCW'(2)) ? ITW'(4 * 32'(l_eff) - 4) : ITW'(2);
    end_calc  = ({1'b0, iteration_count} + (ITW + 1)'(1)) >= {1'b0, total};
    divn_calc = IW'(((32'(interp_count) > MAX_INTERP) ? MAX_INTERP
                                                       : 32'(interp_count)) + 1);
  end

  // Spans between the pitch limits and between the yaw limits.
  always_comb begin
    pdiff   = (ANGLE_W + 1)'(pitch_down) - (ANGLE_W + 1)'(pitch_up);
    pspan   = pdiff[ANGLE_W] ? (ANGLE_W + 1)'(-pdiff) : pdiff;
    ydiff   = (ANGLE_W + 1)'(yaw_left) - (ANGLE_W + 1)'(yaw_right);
    yspan   = ydiff[ANGLE_W] ? (ANGLE_W + 1)'(-ydiff) : ydiff;
    key_yaw = on_right ? yaw_right : yaw_left;
  end

  // Shared multiplier operands: line times span, or yaw times bottom factor.
  always_comb begin
    if (state == ST_PMUL) begin
      mul_a = MUL_W'(pspan);
      mul_b = MUL_W'(line_index);
    end else begin
      mul_a = MUL_W'(yaw_r);
      mul_b = MUL_W'(bottom_yaw_scale);
    end
  end

  // Scaled yaw truncated toward zero, and the two saturating sums.
  always_comb begin
    mround    = mprod + (mprod[PROD_W-1] ? PROD_W'(2 ** SCALE_SHIFT - 1) : PROD_W'(0));
    pitch_sum = SAT_W'(pitch_up) + SAT_W'(div_rsp.quotient);
    point_sum = SAT_W'(yaw_right) + SAT_W'(acc_q);
  end

  // Next scan line, clamped to the current line range.
  always_comb begin
    nl_raw = going_up ? ((LCW + 2)'(line_index) - (LCW + 2)'(1))
                      : ((LCW + 2)'(line_index) + (LCW + 2)'(1));
    nl_max = (LCW + 2)'(l_eff) - (LCW + 2)'(1);
    if (nl_raw < 0) begin
      nl_sat = '0;
    end else if (nl_raw > nl_max) begin
      nl_sat = nl_max;
    end else begin
      nl_sat = nl_raw;
    end
  end

  // Running remainder for the next interpolation point in either direction.
  always_comb begin
    r_dn = RW'(acc_r) - RW'(step_r);
    r_up = RW'(acc_r) + RW'(step_r);
  end

  // Divider requests: line pitch first, then the sweep step.
  always_comb begin
    div_req.start = (state == ST_PDIV) || (state == ST_IDIV);
    if (state == ST_PDIV) begin
      div_req.dividend = mprod[DIV_W-1:0];
      div_req.divisor  = DVS_W'(l_eff - LCW'(1));
    end else begin
      div_req.dividend = DIV_W'(yspan);
      div_req.divisor  = DVS_W'(divn);
    end
  end

  bsg_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // A keyframe leaves when the output register is free or being emptied.
  always_comb begin
    emit_fire = (state == ST_EMIT) && (!out_valid || result.ready);
    emit_last = in_points ? (pts_left == IW'(1)) : !interp_mode;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_lines       <= LINES_W'(RST_SCAN_LINES);
      yaw_left         <= '0;
      yaw_right        <= '0;
      pitch_up         <= '0;
      pitch_down       <= '0;
      bottom_yaw_scale <= SCALE_W'(RST_SCALE);
      interp_count     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SCAN_LINES:   scan_lines       <= cfg.data[LINES_W-1:0];
        REG_YAW_LEFT:     yaw_left         <= cfg.data;
        REG_YAW_RIGHT:    yaw_right        <= cfg.data;
        REG_PITCH_UP:     pitch_up         <= cfg.data;
        REG_PITCH_DOWN:   pitch_down       <= cfg.data;
        REG_BOTTOM_SCALE: bottom_yaw_scale <= cfg.data;
        REG_INTERP_COUNT: interp_count     <= cfg.data[INTERP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with pattern state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      restart_req     <= 1'b0;
      end_flag        <= 1'b0;
      interp_mode     <= 1'b0;
      in_points       <= 1'b0;
      line_index      <= LCW'(RST_LINE_INDEX);
      going_up        <= 1'b1;
      on_right        <= 1'b0;
      heading_right   <= 1'b1;
      iteration_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            restart_req <= item.restart;
            state       <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (restart_req) begin
            line_index      <= l_eff - LCW'(1);
            going_up        <= 1'b1;
            on_right        <= 1'b0;
            heading_right   <= 1'b1;
            iteration_count <= '0;
          end
          state <= ST_PMUL;
        end
        ST_PMUL: begin
          end_flag    <= end_calc;
          in_points   <= 1'b0;
          divn        <= divn_calc;
          interp_mode <= (on_right != heading_right) && (interp_count != '0)
                         && (MAX_INTERP > 0);
          if (l_eff == LCW'(1)) begin
            pitch_r <= pitch_up;
            yaw_r   <= key_yaw;
            state   <= ST_YSCL;
          end else begin
            mprod <= mul_a * mul_b;
            state <= ST_PDIV;
          end
        end
        ST_PDIV: begin
          state <= ST_PWAIT;
        end
        ST_PWAIT: begin
          if (div_rsp.done) begin
            pitch_r <= sat_angle(pitch_sum);
            yaw_r   <= key_yaw;
            state   <= ST_YSCL;
          end
        end
        ST_YSCL: begin
          if (pitch_r == pitch_down) begin
            mprod <= mul_a * mul_b;
            state <= ST_YRND;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_YRND: begin
          yaw_r <= sat_angle(SAT_W'(mround >>> SCALE_SHIFT));
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            if (!in_points && interp_mode) begin
              state <= ST_IDIV;
            end else if (in_points && !emit_last) begin
              state <= ST_STEP;
            end else begin
              state <= ST_UPD;
            end
          end
        end
        ST_IDIV: begin
          state <= ST_IWAIT;
        end
        ST_IWAIT: begin
          if (div_rsp.done) begin
            step_q    <= div_rsp.quotient[ANGLE_W:0];
            step_r    <= div_rsp.remainder;
            pts_left  <= divn;
            in_points <= 1'b1;
            // Rightward sweeps start at the far end, where the point is exact.
            if (heading_right) begin
              acc_q <= yspan;
              acc_r <= '0;
            end else begin
              acc_q <= div_rsp.quotient[ANGLE_W:0];
              acc_r <= div_rsp.remainder;
            end
            state <= ST_POINT;
          end
        end
        ST_POINT: begin
          yaw_r <= sat_angle(point_sum);
          state <= ST_YSCL;
        end
        ST_STEP: begin
          pts_left <= pts_left - IW'(1);
          if (heading_right) begin
            if (r_dn[RW-1]) begin
              acc_r <= DVS_W'(r_dn + RW'(divn));
              acc_q <= acc_q - step_q - (ANGLE_W + 1)'(1);
            end else begin
              acc_r <= DVS_W'(r_dn);
              acc_q <= acc_q - step_q;
            end
          end else begin
            if (r_up >= RW'(divn)) begin
              acc_r <= DVS_W'(r_up - RW'(divn));
              acc_q <= acc_q + step_q + (ANGLE_W + 1)'(1);
            end else begin
              acc_r <= DVS_W'(r_up);
              acc_q <= acc_q + step_q;
            end
          end
          state <= ST_POINT;
        end
        ST_UPD: begin
          if (end_flag) begin
            line_index      <= l_eff - LCW'(1);
            going_up        <= 1'b1;
            on_right        <= 1'b0;
            heading_right   <= 1'b1;
            iteration_count <= '0;
          end else begin
            iteration_count <= iteration_count + ITW'(1);
            if (on_right != heading_right) begin
              on_right <= heading_right;
            end else begin
              heading_right <= !heading_right;
              line_index    <= LCW'(nl_sat);
              if (nl_sat <= 0 || nl_sat >= nl_max) begin
                going_up <= !going_up;
              end
            end
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_yaw   <= yaw_r;
      out_pitch <= pitch_r;
      out_last  <= emit_last;
      out_end   <= end_flag;
    end
  end

  assign item.ready          = (state == ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign result.valid        = out_valid;
  assign result.yaw          = out_yaw;
  assign result.pitch        = out_pitch;
  assign result.last_of_step = out_last;
  assign result.pattern_end  = out_end;

endmodule

### tb/boustrophedon_scan_generator_test.sv
// Self-checking testbench for the back-and-forth pan-tilt scan pattern generator.
`timescale 1ns / 1ps

module boustrophedon_scan_generator_test;
  import bsg_pkg::*;

  localparam int MAX_LINES      = 16;
  localparam int MAX_INTERP     = 15;
  localparam int HALF_PERIOD    = 4;
  localparam int IDLE_PCT       = 6;
  localparam int SETTLE_CYCLES  = 96;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam longint SCALE_ONE  = longint'(1) <<< SCALE_SHIFT;
  localparam longint ANGLE_MAX  = (longint'(1) <<< (ANGLE_W - 1)) - 1;
  localparam longint ANGLE_MIN  = -ANGLE_MAX - 1;

  // One step request: the restart bit, plus a hold that keeps it back until all
  // keyframes owed so far have come out.
  typedef struct packed {
    logic restart;
    logic hold;
  } step_req_t;

  // One keyframe as it leaves the block.
  typedef struct {
    logic signed [ANGLE_W-1:0] yaw;
    logic signed [ANGLE_W-1:0] pitch;
    logic                      last_of_step;
    logic                      pattern_end;
  } keyframe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsg_item_if   step_ch();
  bsg_result_if frame_ch();
  bsg_cfg_if    cfg_ch();

  boustrophedon_scan_generator #(
    .MAX_LINES (MAX_LINES),
    .MAX_INTERP(MAX_INTERP)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (step_ch),
    .result(frame_ch),
    .cfg   (cfg_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Register copies as the block should hold them.
  logic [LINES_W-1:0]        reg_lines;
  logic signed [ANGLE_W-1:0] reg_yaw_left;
  logic signed [ANGLE_W-1:0] reg_yaw_right;
  logic signed [ANGLE_W-1:0] reg_pitch_up;
  logic signed [ANGLE_W-1:0] reg_pitch_down;
  logic [SCALE_W-1:0]        reg_scale;
  logic [INTERP_W-1:0]       reg_interp;

  // Scan position of the pattern.
  int row;
  bit rising;
  bit at_right;
  bit heading_right;
  int iter_count;

  step_req_t pending_steps[$];
  keyframe_t owed_frames[$];

  bit steady = 1'b0;
  bit step_taken = 1'b0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int steps_done = 0;
  int frames_done = 0;
  int cfg_beats = 0;
  int settings_used = 0;
  int pattern_ends = 0;
  int point_sweeps = 0;

  function automatic logic signed [ANGLE_W-1:0] clamp_angle(input longint v);
    if (v > ANGLE_MAX) return ANGLE_W'(ANGLE_MAX);
    if (v < ANGLE_MIN) return ANGLE_W'(ANGLE_MIN);
    return ANGLE_W'(v);
  endfunction

  function automatic int active_lines();
    int l;
    l = int'(reg_lines);
    if (l < 1) l = 1;
    if (l > MAX_LINES) l = MAX_LINES;
    return l;
  endfunction

  function automatic void restart_scan();
    row = active_lines() - 1;
    rising = 1'b1;
    at_right = 1'b0;
    heading_right = 1'b1;
    iter_count = 0;
  endfunction

  // Pitch of a scan line: evenly spread from the top edge by |down - up|.
  function automatic logic signed [ANGLE_W-1:0] row_pitch(input int r, input int l);
    longint span;
    if (l <= 1) return clamp_angle(longint'(reg_pitch_up));
    span = longint'(reg_pitch_down) - longint'(reg_pitch_up);
    if (span < 0) span = -span;
    return clamp_angle(longint'(reg_pitch_up) + (longint'(r) * span) / longint'(l - 1));
  endfunction

  // Keyframes exactly on the bottom edge get their yaw scaled.
  function automatic keyframe_t make_frame(input longint yaw_v,
                                           input logic signed [ANGLE_W-1:0] pitch_v,
                                           input bit ends);
    keyframe_t f;
    if (pitch_v == reg_pitch_down) begin
      yaw_v = longint'(clamp_angle((yaw_v * longint'(reg_scale)) / SCALE_ONE));
    end
    f.yaw = clamp_angle(yaw_v);
    f.pitch = pitch_v;
    f.last_of_step = 1'b0;
    f.pattern_end = ends;
    return f;
  endfunction

  // Advance the pattern by one iteration and queue the keyframes it owes.
  function automatic void advance_pattern(input logic restart);
    keyframe_t frames[$];
    int l;
    int total;
    longint span;
    longint steps;
    longint j;
    longint next_row;
    logic signed [ANGLE_W-1:0] pitch_v;
    bit ends;
    if (restart) restart_scan();
    l = active_lines();
    total = (l * 4 > 6) ? l * 4 - 4 : 2;
    ends = (iter_count + 1 >= total);
    pitch_v = row_pitch(row, l);
    frames = {frames, make_frame(longint'(at_right ? reg_yaw_right : reg_yaw_left),
                                 pitch_v, ends)};

    if (at_right != heading_right) begin
      // Horizontal sweep: corner, then the points across, backwards when heading right.
      if (reg_interp != 0) begin
        steps = longint'(reg_interp) + 1;
        span = longint'(reg_yaw_left) - longint'(reg_yaw_right);
        if (span < 0) span = -span;
        for (longint i = 1; i <= steps; i++) begin
          j = heading_right ? steps + 1 - i : i;
          frames = {frames, make_frame(
            longint'(clamp_angle(longint'(reg_yaw_right) + (span * j) / steps)),
            pitch_v, ends)};
        end
        point_sweeps++;
      end
      at_right = heading_right;
    end else begin
      // Vertical move: step one line, bounce at the edges.
      next_row = longint'(row) + (rising ? -1 : 1);
      heading_right = !heading_right;
      if (next_row < 0) next_row = 0;
      if (next_row > l - 1) next_row = l - 1;
      row = int'(next_row);
      if (next_row <= 0 || next_row >= l - 1) rising = !rising;
    end

    if (ends) begin
      restart_scan();
      pattern_ends++;
    end else begin
      iter_count++;
    end

    frames[$].last_of_step = 1'b1;
    owed_frames = {owed_frames, frames};
  endfunction

  // Step driver: a new beat is offered only once the previous one was taken.
  always @(negedge clk) begin : step_driver
    step_req_t nxt;
    if (rst) begin
      step_ch.valid <= 1'b0;
      step_ch.restart <= 1'b0;
    end else if (!step_ch.valid || step_taken) begin
      if (pending_steps.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)
          && !(pending_steps[0].hold && owed_frames.size() != 0)) begin
        nxt = pending_steps.pop_front();
        step_ch.valid <= 1'b1;
        step_ch.restart <= nxt.restart;
      end else begin
        step_ch.valid <= 1'b0;
        step_ch.restart <= 1'b0;
      end
    end
  end

  // Keyframe consumer stalls at random outside the steady stretch.
  always @(negedge clk) begin
    frame_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor: predicts on every step beat, checks every keyframe beat, runs the watchdog.
  always @(posedge clk) begin : monitor
    keyframe_t want;
    bit step_beat;
    bit frame_beat;
    bit cfg_beat;
    step_beat = !rst && step_ch.valid && step_ch.ready;
    frame_beat = !rst && frame_ch.valid && frame_ch.ready;
    cfg_beat = !rst && cfg_ch.valid && cfg_ch.ready;
    step_taken <= step_beat;

    if (step_beat) begin
      advance_pattern(step_ch.restart);
      steps_done++;
    end

    if (frame_beat) begin
      frames_done++;
      if (owed_frames.size() == 0) begin
        $error("keyframe beat with none expected: yaw %0d pitch %0d",
               frame_ch.yaw, frame_ch.pitch);
        mismatches++;
      end else begin
        want = owed_frames.pop_front();
        if (frame_ch.yaw !== want.yaw) begin
          $error("yaw: expected %0d, got %0d", want.yaw, frame_ch.yaw);
          mismatches++;
        end
        if (frame_ch.pitch !== want.pitch) begin
          $error("pitch: expected %0d, got %0d", want.pitch, frame_ch.pitch);
          mismatches++;
        end
        if (frame_ch.last_of_step !== want.last_of_step) begin
          $error("last_of_step: expected %0d, got %0d", want.last_of_step,
                 frame_ch.last_of_step);
          mismatches++;
        end
        if (frame_ch.pattern_end !== want.pattern_end) begin
          $error("pattern_end: expected %0d, got %0d", want.pattern_end,
                 frame_ch.pattern_end);
          mismatches++;
        end
      end
    end

    if (step_beat || frame_beat || cfg_beat) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d keyframes still owed",
               quiet_cycles, owed_frames.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // One register write; the copy is updated once the beat is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_beats++;
    case (idx)
      REG_SCAN_LINES:   reg_lines = value[LINES_W-1:0];
      REG_YAW_LEFT:     reg_yaw_left = value;
      REG_YAW_RIGHT:    reg_yaw_right = value;
      REG_PITCH_UP:     reg_pitch_up = value;
      REG_PITCH_DOWN:   reg_pitch_down = value;
      REG_BOTTOM_SCALE: reg_scale = value;
      REG_INTERP_COUNT: reg_interp = value[INTERP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] lines, input logic [15:0] yl,
                              input logic [15:0] yr, input logic [15:0] pu,
                              input logic [15:0] pd, input logic [15:0] scale,
                              input logic [15:0] points);
    write_reg(REG_SCAN_LINES, lines);
    write_reg(REG_YAW_LEFT, yl);
    write_reg(REG_YAW_RIGHT, yr);
    write_reg(REG_PITCH_UP, pu);
    write_reg(REG_PITCH_DOWN, pd);
    write_reg(REG_BOTTOM_SCALE, scale);
    write_reg(REG_INTERP_COUNT, points);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_step(input bit restart, input bit hold);
    step_req_t s;
    s.restart = restart;
    s.hold = hold;
    pending_steps = {pending_steps, s};
  endtask

  // Wait for every step to be taken and every keyframe to come out, then let the
  // block finish its current pass.
  task automatic settle();
    while (pending_steps.size() != 0 || step_ch.valid || owed_frames.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 8192) - 4096);
  endfunction

  // A random setting followed by a run of steps; most steps just walk the pattern.
  task automatic random_phase(input int count, input bit calm, input int hold_at);
    logic [15:0] lines;
    logic [15:0] pu;
    logic [15:0] pd;
    logic [15:0] scale;
    logic [15:0] points;
    bit first_restart;
    case ($urandom_range(0, 9))
      0:       lines = 16'd0;
      1:       lines = 16'd16;
      2:       lines = 16'($urandom_range(17, 31));
      default: lines = 16'($urandom_range(1, 5));
    endcase
    lines = {11'($urandom), lines[4:0]};
    pu = pick_angle();
    case ($urandom_range(0, 2))
      0:       pd = pu;
      1:       pd = pu + 16'($urandom_range(0, 6000));
      default: pd = pick_angle();
    endcase
    case ($urandom_range(0, 4))
      0:       scale = 16'd16384;
      1:       scale = 16'd0;
      2:       scale = 16'hffff;
      default: scale = 16'($urandom);
    endcase
    points = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 15));
    points = {12'($urandom), points[3:0]};
    program_regs(lines, pick_angle(), pick_angle(), pu, pd, scale, points);

    steady = calm;
    first_restart = $urandom_range(0, 1);
    for (int i = 0; i < count; i++) begin
      queue_step((i == 0 && first_restart) || $urandom_range(0, 99) < 4,
                 i == hold_at || $urandom_range(0, 99) < 3);
    end
    settle();
    steady = 1'b0;
  endtask

  initial begin
    step_ch.valid = 1'b0;
    step_ch.restart = 1'b0;
    frame_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SCAN_LINES;
    cfg_ch.data = '0;

    reg_lines = LINES_W'(RST_SCAN_LINES);
    reg_yaw_left = '0;
    reg_yaw_right = '0;
    reg_pitch_up = '0;
    reg_pitch_down = '0;
    reg_scale = SCALE_W'(RST_SCALE);
    reg_interp = '0;
    restart_scan();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting: three lines, all limits zero, so every keyframe sits on the
    // bottom edge; one restart in the middle.
    settings_used++;
    for (int i = 0; i < 6; i++) queue_step(i == 3, 1'b0);
    settle();

    // Zero lines acts as one; widest yaw span with the most points saturates.
    program_regs(16'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff, 16'd15);
    for (int i = 0; i < 3; i++) queue_step(1'b0, 1'b0);
    settle();

    // Line count above the maximum; the start line lands exactly on the bottom
    // edge, where a zero factor flattens the yaw.
    program_regs(16'd31, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'd0, 16'd1);
    for (int i = 0; i < 6; i++) queue_step(i == 0, 1'b0);
    settle();

    // Fewer lines without a restart: line index and iteration count are both past
    // the new pattern, so pitch saturates and the pattern ends at once.
    program_regs(16'd2, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'd0, 16'd1);
    for (int i = 0; i < 4; i++) queue_step(1'b0, 1'b0);
    settle();

    // Single line on the bottom edge with the largest factor: scaled yaw saturates.
    program_regs(16'd1, 16'h7fff, 16'h8000, 16'h1000, 16'h1000, 16'hffff, 16'd2);
    for (int i = 0; i < 5; i++) queue_step(i == 0, 1'b0);
    settle();

    // Random settings; one phase runs with no idling on either side.
    for (int p = 0; p < 7; p++) begin
      random_phase(27, p == 3, (p == 0) ? 12 : -1);
    end

    $display("Ran %0d steps through %0d settings (%0d register writes).",
             steps_done, settings_used, cfg_beats);
    $display("Checked %0d keyframes: %0d pattern ends, %0d sweeps with points.",
             frames_done, pattern_ends, point_sweeps);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
